// ===== hdl/esto_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package esto_pkg;

	// Floor space and batch limit
	localparam int FLOORS      = 1024;
	localparam int MAX_BUTTONS = 64;
	localparam int FLOOR_W     = 10;
	localparam int CNT_W       = $clog2(MAX_BUTTONS + 1);

	// Floor map is stored as rows of ROW_W floors
	localparam int ROW_W  = 32;
	localparam int ROWS   = FLOORS / ROW_W;
	localparam int BIT_AW = $clog2(ROW_W);
	localparam int ROW_AW = FLOOR_W - BIT_AW;

	// Travel direction codes
	localparam logic signed [1:0] DIR_UP   = 2'sb01;
	localparam logic signed [1:0] DIR_DOWN = 2'sb11;

	typedef logic [ROW_W-1:0] row_t;

	// One access to the floor map memory
	typedef struct packed {
		logic              re;
		logic [ROW_AW-1:0] raddr;
		logic              we;
		logic [ROW_AW-1:0] waddr;
		row_t              wdata;
	} mem_req_t;

	// Batch hand-off from the press path to the scanner
	typedef struct packed {
		logic               start;
		logic [FLOOR_W-1:0] cur_floor;
		logic signed [1:0]  dir;
		logic               ovf;
	} batch_t;

	// Lowest set bit (asc) or highest set bit (!asc) of a row
	function automatic logic [BIT_AW-1:0] first_set(input row_t v, input logic asc);
		logic [BIT_AW-1:0] pos;
		pos = '0;
		if (asc) begin
			for (int i = ROW_W - 1; i >= 0; i--) begin
				if (v[i]) pos = BIT_AW'(i);
			end
		end else begin
			for (int i = 0; i < ROW_W; i++) begin
				if (v[i]) pos = BIT_AW'(i);
			end
		end
		return pos;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/esto_map_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module esto_map_ram import esto_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              re,
	input  wire logic [ROW_AW-1:0] raddr,
	output row_t                   rdata,
	input  wire logic              we,
	input  wire logic [ROW_AW-1:0] waddr,
	input  wire row_t              wdata
);

	row_t            mem_q [ROWS];
	row_t            rdata_q;
	logic [ROWS-1:0] vld_q;
	logic            rvld_q;

	// Row valid bits: a row never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) vld_q[waddr] <= 1'b1;
			if (re) rvld_q <= vld_q[raddr];
		end
	end

	// Storage, read-before-write on a shared address
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata_q <= mem_q[raddr];
	end

	assign rdata = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire

// ===== hdl/esto_press.sv =====
`timescale 1ns / 1ps
`default_nettype none

module esto_press import esto_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               acc,
	input  wire logic [FLOOR_W-1:0] floor,
	input  wire logic [FLOOR_W-1:0] current_floor,
	input  wire logic signed [1:0]  direction,
	input  wire logic               last,
	input  wire row_t               rdata,
	output mem_req_t                req,
	output batch_t                  batch
);

	logic [CNT_W-1:0]  count_q;
	logic              drop_q;
	logic              press_ok;
	logic              valid_s1;
	logic [ROW_AW-1:0] row_s1;
	logic [BIT_AW-1:0] bit_s1;
	logic              fwd_valid_q;
	logic [ROW_AW-1:0] fwd_row_q;
	row_t              fwd_data_q;
	row_t              base;
	row_t              wdata;
	logic              start_q;
	logic [FLOOR_W-1:0] cur_q;
	logic signed [1:0] dir_q;
	logic              ovf_q;

	assign press_ok = count_q < CNT_W'(MAX_BUTTONS);

	// Batch counters and the read stage of the row update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			drop_q      <= 1'b0;
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
			start_q     <= 1'b0;
		end else begin
			valid_s1    <= acc & press_ok;
			fwd_valid_q <= valid_s1;
			start_q     <= acc & last;
			if (acc) begin
				if (last) begin
					count_q <= '0;
					drop_q  <= 1'b0;
				end else if (press_ok) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					drop_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			row_s1 <= floor[FLOOR_W-1:BIT_AW];
			bit_s1 <= floor[BIT_AW-1:0];
		end
		if (acc && last) begin
			cur_q <= current_floor;
			dir_q <= direction;
			ovf_q <= drop_q | ~press_ok;
		end
		fwd_row_q  <= row_s1;
		fwd_data_q <= wdata;
	end

	// Set the pressed bit; forward the previous write to the same row
	always_comb begin
		base  = (fwd_valid_q && (fwd_row_q == row_s1)) ? fwd_data_q : rdata;
		wdata = base | (row_t'(1) << bit_s1);
	end

	assign req.re    = acc;
	assign req.raddr = floor[FLOOR_W-1:BIT_AW];
	assign req.we    = valid_s1;
	assign req.waddr = row_s1;
	assign req.wdata = wdata;

	assign batch.start     = start_q;
	assign batch.cur_floor = cur_q;
	assign batch.dir       = dir_q;
	assign batch.ovf       = ovf_q;

endmodule

`default_nettype wire

// ===== hdl/esto_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none

module esto_scan import esto_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire batch_t              batch,
	input  wire row_t                rdata,
	output mem_req_t                 req,
	output logic                     busy,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [FLOOR_W-1:0]       stop_floor,
	output logic                     empty_res,
	output logic                     overflow,
	output logic                     last_stop
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RD   = 5'b00010,
		S_LD   = 5'b00100,
		S_EMIT = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t             state_q;
	logic [FLOOR_W-1:0] cur_q;
	logic               emit_en_q;
	logic               up_q;
	logic               asc_q;
	logic               phase2_q;
	logic               first_q;
	logic               ovf_q;
	logic [ROW_AW-1:0]  row_q;
	row_t               saved_q;
	row_t               work_q;
	logic               pend_valid_q;
	logic [FLOOR_W-1:0] pend_q;
	logic               out_valid_q;

	logic [BIT_AW-1:0]  cur_bit;
	row_t               hi_mask;
	row_t               lo_mask;
	logic               found;
	logic [BIT_AW-1:0]  pos;
	logic               out_free;
	logic               take;
	logic               push_mid;
	logic               push_fin;
	logic               at_end;

	// Row masks around the car floor, bit search in the working row
	always_comb begin
		cur_bit  = cur_q[BIT_AW-1:0];
		hi_mask  = {ROW_W{1'b1}} << cur_bit;
		lo_mask  = ~hi_mask;
		found    = |work_q;
		pos      = first_set(work_q, asc_q);
		out_free = ~out_valid_q | out_ready;
		take     = (state_q == S_EMIT) && found && (!pend_valid_q || out_free);
		push_mid = take && pend_valid_q;
		push_fin = (state_q == S_FIN) && out_free;
		at_end   = asc_q ? (row_q == ROW_AW'(ROWS - 1)) : (row_q == '0);
	end

	// Sequencer: each row is read once and written back as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			emit_en_q    <= 1'b0;
			up_q         <= 1'b0;
			asc_q        <= 1'b0;
			phase2_q     <= 1'b0;
			first_q      <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (batch.start) begin
						emit_en_q <= (batch.dir == DIR_UP) || (batch.dir == DIR_DOWN);
						up_q      <= batch.dir != DIR_DOWN;
						asc_q     <= batch.dir != DIR_DOWN;
						phase2_q  <= 1'b0;
						first_q   <= 1'b1;
						state_q   <= S_RD;
					end
				end
				S_RD: state_q <= S_LD;
				S_LD: begin
					first_q <= 1'b0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (found) begin
						if (take) pend_valid_q <= 1'b1;
					end else if (!at_end) begin
						state_q <= S_RD;
					end else if (!phase2_q) begin
						phase2_q <= 1'b1;
						asc_q    <= ~up_q;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (push_mid || push_fin) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Row data, pending stop and the output register
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && batch.start) begin
			cur_q <= batch.cur_floor;
			ovf_q <= batch.ovf;
			row_q <= batch.cur_floor[FLOOR_W-1:BIT_AW];
		end
		if (state_q == S_LD) begin
			if (first_q) saved_q <= rdata;
			if (!emit_en_q) work_q <= '0;
			else if (first_q) work_q <= rdata & (up_q ? hi_mask : lo_mask);
			else work_q <= rdata;
		end
		if (state_q == S_EMIT) begin
			if (found) begin
				if (take) begin
					work_q <= work_q & ~(row_t'(1) << pos);
					pend_q <= {row_q, pos};
				end
			end else if (!at_end) begin
				row_q <= asc_q ? row_q + ROW_AW'(1) : row_q - ROW_AW'(1);
			end else if (!phase2_q) begin
				row_q  <= cur_q[FLOOR_W-1:BIT_AW];
				work_q <= emit_en_q ? (saved_q & (up_q ? lo_mask : hi_mask)) : '0;
			end
		end
		if (push_mid) begin
			stop_floor <= pend_q;
			empty_res  <= 1'b0;
			overflow   <= ovf_q;
			last_stop  <= 1'b0;
		end else if (push_fin) begin
			stop_floor <= pend_valid_q ? pend_q : '0;
			empty_res  <= ~pend_valid_q;
			overflow   <= ovf_q;
			last_stop  <= 1'b1;
		end
	end

	assign req.re    = (state_q == S_RD);
	assign req.raddr = row_q;
	assign req.we    = (state_q == S_LD);
	assign req.waddr = row_q;
	assign req.wdata = '0;

	assign busy      = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/elevator_stop_order.sv =====
// Orders one batch of elevator stops, LOOK style. Each press transaction marks
// its floor in a 1024-floor map held in a 32 x 32-bit memory; repeated floors
// merge, and presses past 64 in a batch are dropped and reported through
// overflow on every result of that batch. Presses are taken one per
// cycle while press_ready is high. The transaction flagged last samples
// current_floor and direction, then the block stops taking presses while it
// scans the memory row by row: up gives the floors at or above the car
// rising, then those below falling; down the reverse; any other direction,
// or an empty map, gives a single result with empty_res set. last_stop marks
// the final result. The scan reads, loads and tests each memory row in turn
// and hands out stops as it finds them, stalling while stop_ready is low;
// it also leaves the map cleared for the next batch.
`timescale 1ns / 1ps
`default_nettype none

module elevator_stop_order import esto_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               press_valid,
	output logic                    press_ready,
	input  wire logic [FLOOR_W-1:0] floor,
	input  wire logic [FLOOR_W-1:0] current_floor,
	input  wire logic signed [1:0]  direction,
	input  wire logic               last,
	output logic                    stop_valid,
	input  wire logic               stop_ready,
	output logic [FLOOR_W-1:0]      stop_floor,
	output logic                    empty_res,
	output logic                    overflow,
	output logic                    last_stop
);

	logic     acc;
	logic     busy;
	batch_t   batch;
	mem_req_t press_req;
	mem_req_t scan_req;
	mem_req_t mem_req;
	row_t     rdata;

	// No presses while a batch is being drained or scanned
	assign press_ready = ~busy & ~batch.start;
	assign acc         = press_valid & press_ready;

	// Memory port goes to the scanner while it runs
	assign mem_req = busy ? scan_req : press_req;

	esto_map_ram u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (mem_req.re),
		.raddr  (mem_req.raddr),
		.rdata  (rdata),
		.we     (mem_req.we),
		.waddr  (mem_req.waddr),
		.wdata  (mem_req.wdata)
	);

	esto_press u_press (
		.clk           (clk),
		.arst_n        (arst_n),
		.acc           (acc),
		.floor         (floor),
		.current_floor (current_floor),
		.direction     (direction),
		.last          (last),
		.rdata         (rdata),
		.req           (press_req),
		.batch         (batch)
	);

	esto_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.batch      (batch),
		.rdata      (rdata),
		.req        (scan_req),
		.busy       (busy),
		.out_valid  (stop_valid),
		.out_ready  (stop_ready),
		.stop_floor (stop_floor),
		.empty_res  (empty_res),
		.overflow   (overflow),
		.last_stop  (last_stop)
	);

endmodule

`default_nettype wire
